/* rtl/core/bnis_pkg.sv */
// ============================================================================
// Batch normalization int8 stream package
// Shared types, register indexes, opcodes and constants of the block.
// ============================================================================
package bnis_pkg;

    localparam int DEF_MAX_CHANNELS = 256;
    localparam int DEF_MAX_INNER    = 65536;

    localparam int EPS_W       = 24;
    localparam int NUM_CH_W    = 9;
    localparam int INNER_LEN_W = 17;
    localparam int CFG_ADDR_W  = 2;

    localparam logic [CFG_ADDR_W-1:0] CFG_EPSILON        = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_CHANNELS_FIRST = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_NUM_CHANNELS   = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_INNER_LENGTH   = 2'd3;

    localparam logic [EPS_W-1:0]       EPS_RESET       = 24'd168;
    localparam logic                   CH_FIRST_RESET  = 1'b1;
    localparam logic [NUM_CH_W-1:0]    NUM_CH_RESET    = 9'd256;
    localparam logic [INNER_LEN_W-1:0] INNER_LEN_RESET = 17'd1;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_DATA = 1'b1;

    localparam int RES_MAX = 127;
    localparam int RES_MIN = -128;

    typedef struct packed {
        logic [EPS_W-1:0]       eps;
        logic                   ch_first;
        logic [NUM_CH_W-1:0]    num_ch;
        logic [INNER_LEN_W-1:0] inner_len;
    } t_cfg;

    typedef struct packed {
        logic signed [7:0] p_var;
        logic signed [7:0] mean;
        logic signed [7:0] beta;
        logic signed [7:0] gamma;
    } t_entry;

    typedef struct packed {
        logic [7:0] result;
        logic       clipped;
        logic       invalid;
        logic       last;
    } t_result;

endpackage

/* rtl/core/batch_norm_int8_stream_core.sv */
// A data item passes fetch, squaring, a nine-step root search and two check steps
// on the shared unit, and rounding; when var + eps is not positive, fetch goes
// straight to rounding. A load item is written in its accept cycle. Throughput:
// one load item per cycle while no data item is in work; a new data item waits
// until the last is rounded into the output register. Reset: synchronous active-low;
// counters, state and registers return to defaults; the channel table is kept.
// ============================================================================
// Batch normalization int8 stream core
// Top level: configuration registers, channel table, position counter and
// the arithmetic sequencer with its output register.
// ============================================================================
module batch_norm_int8_stream_core #(
    parameter int MAX_CHANNELS = bnis_pkg::DEF_MAX_CHANNELS,
    parameter int MAX_INNER    = bnis_pkg::DEF_MAX_INNER
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic                            i_cfg_we,
    input  logic [bnis_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [bnis_pkg::EPS_W-1:0]      i_cfg_wdata,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // channel, param_gamma, param_beta, param_mean, param_var, sample
    input  logic [47:0] s_axis_tdata,
    // opcode
    input  logic        s_axis_tuser,
    input  logic        s_axis_tlast,

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // result
    output logic [7:0]  m_axis_tdata,
    // clipped, invalid
    output logic [1:0]  m_axis_tuser,
    output logic        m_axis_tlast
);
    import bnis_pkg::*;

    localparam int AW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

    t_cfg          r_cfg;
    logic          in_accept;
    logic          ram_we;
    logic          norm_start;
    logic          norm_idle;
    logic [AW-1:0] pos_addr;
    logic [31:0]   ram_wdata;
    t_entry        ram_rdata;
    t_result       norm_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.eps       <= EPS_RESET;
            r_cfg.ch_first  <= CH_FIRST_RESET;
            r_cfg.num_ch    <= NUM_CH_RESET;
            r_cfg.inner_len <= INNER_LEN_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_EPSILON:        r_cfg.eps       <= i_cfg_wdata;
                CFG_CHANNELS_FIRST: r_cfg.ch_first  <= i_cfg_wdata[0];
                CFG_NUM_CHANNELS:   r_cfg.num_ch    <= i_cfg_wdata[NUM_CH_W-1:0];
                CFG_INNER_LENGTH:   r_cfg.inner_len <= i_cfg_wdata[INNER_LEN_W-1:0];
                default:            r_cfg           <= r_cfg;
            endcase
        end
    end

    assign s_axis_tready = norm_idle;
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign norm_start    = in_accept && (s_axis_tuser == OP_DATA);
    assign ram_we        = in_accept && (s_axis_tuser == OP_LOAD) &&
                           (32'(s_axis_tdata[7:0]) < MAX_CHANNELS);
    assign ram_wdata     = s_axis_tdata[39:8];

    bnis_ram #(
        .WIDTH (32),
        .DEPTH (MAX_CHANNELS),
        .AW    (AW)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (AW'(s_axis_tdata[7:0])),
        .i_wdata (ram_wdata),
        .i_raddr (pos_addr),
        .o_rdata (ram_rdata)
    );

    bnis_pos #(
        .MAX_CHANNELS (MAX_CHANNELS),
        .MAX_INNER    (MAX_INNER),
        .AW           (AW)
    ) u_pos (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_step    (norm_start),
        .i_restart (in_accept && s_axis_tlast),
        .o_addr    (pos_addr)
    );

    bnis_norm u_norm (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (norm_start),
        .i_sample (s_axis_tdata[47:40]),
        .i_last   (s_axis_tlast),
        .i_eps    (r_cfg.eps),
        .i_entry  (ram_rdata),
        .o_idle   (norm_idle),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_result (norm_result)
    );

    assign m_axis_tdata = norm_result.result;
    assign m_axis_tuser = {norm_result.invalid, norm_result.clipped};
    assign m_axis_tlast = norm_result.last;

`ifndef SYNTH
    a_data_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        norm_start |=> !s_axis_tready)
        else $error("input ready while a data item is in work");

    a_invalid_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[1]) |-> ((m_axis_tdata == '0) && !m_axis_tuser[0]))
        else $error("invalid result with nonzero value or clip flag");

    a_addr_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        norm_start |-> (32'(pos_addr) < MAX_CHANNELS))
        else $error("channel address beyond table depth");

    a_no_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (norm_start && !m_axis_tvalid) |=> !m_axis_tvalid)
        else $error("result appeared one cycle after a data item");
`endif

endmodule

/* rtl/core/bnis_ram.sv */
// ============================================================================
// Generic single-port-write RAM
// One write port and one read port; the read data is registered.
// ============================================================================
module bnis_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/bnis_pos.sv */
// ============================================================================
// Batch normalization position counter
// Tracks the channel and inner position of each data item in the stream.
// ============================================================================
module bnis_pos #(
    parameter int MAX_CHANNELS = bnis_pkg::DEF_MAX_CHANNELS,
    parameter int MAX_INNER    = bnis_pkg::DEF_MAX_INNER,
    parameter int AW           = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  bnis_pkg::t_cfg i_cfg,
    input  logic           i_step,
    input  logic           i_restart,
    output logic [AW-1:0]  o_addr
);
    import bnis_pkg::*;

    localparam int CLW = ($clog2(MAX_CHANNELS + 1) > NUM_CH_W) ?
                         $clog2(MAX_CHANNELS + 1) : NUM_CH_W;
    localparam int IW  = (MAX_INNER > 1) ? $clog2(MAX_INNER) : 1;
    localparam int ILW = ($clog2(MAX_INNER + 1) > INNER_LEN_W) ?
                         $clog2(MAX_INNER + 1) : INNER_LEN_W;

    logic [AW-1:0]  r_ch;
    logic [IW-1:0]  r_in;
    logic [AW-1:0]  n_ch;
    logic [IW-1:0]  n_in;
    logic [CLW-1:0] lim_c;
    logic [CLW-1:0] inc_c;
    logic [ILW-1:0] lim_i;
    logic [ILW-1:0] inc_i;
    logic [AW-1:0]  cur_c;
    logic [AW-1:0]  adv_c;
    logic [IW-1:0]  cur_i;

    always_comb begin
        if (i_cfg.num_ch == '0) begin
            lim_c = CLW'(1);
        end else if (CLW'(i_cfg.num_ch) > CLW'(MAX_CHANNELS)) begin
            lim_c = CLW'(MAX_CHANNELS);
        end else begin
            lim_c = CLW'(i_cfg.num_ch);
        end
        if (i_cfg.inner_len == '0) begin
            lim_i = ILW'(1);
        end else if (ILW'(i_cfg.inner_len) > ILW'(MAX_INNER)) begin
            lim_i = ILW'(MAX_INNER);
        end else begin
            lim_i = ILW'(i_cfg.inner_len);
        end

        cur_c = (CLW'(r_ch) >= lim_c) ? '0 : r_ch;
        cur_i = (ILW'(r_in) >= lim_i) ? '0 : r_in;
        inc_c = CLW'(cur_c) + CLW'(1);
        inc_i = ILW'(cur_i) + ILW'(1);
        adv_c = (inc_c >= lim_c) ? '0 : AW'(inc_c);

        if (i_cfg.ch_first) begin
            if (inc_i >= lim_i) begin
                n_in = '0;
                n_ch = adv_c;
            end else begin
                n_in = IW'(inc_i);
                n_ch = cur_c;
            end
        end else begin
            n_in = '0;
            n_ch = adv_c;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ch <= '0;
            r_in <= '0;
        end else if (i_restart) begin
            r_ch <= '0;
            r_in <= '0;
        end else if (i_step) begin
            r_ch <= n_ch;
            r_in <= n_in;
        end
    end

    assign o_addr = cur_c;

endmodule

/* rtl/core/bnis_norm.sv */
// ============================================================================
// Batch normalization arithmetic sequencer
// Computes beta + gamma*(x-mean)/sqrt(var+eps) exactly by a bit-serial
// root search on one shared square-and-scale unit, then rounds and clips.
// ============================================================================
module bnis_norm (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [7:0]                       i_sample,
    input  logic                             i_last,
    input  logic [bnis_pkg::EPS_W-1:0]       i_eps,
    input  bnis_pkg::t_entry                 i_entry,
    output logic                             o_idle,
    output logic                             o_valid,
    input  logic                             i_ready,
    output bnis_pkg::t_result                o_result
);
    import bnis_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FETCH,
        S_ABS,
        S_SQ,
        S_PD,
        S_CMP,
        S_RND
    } t_state;

    typedef enum logic [1:0] {
        PH_SEARCH,
        PH_EXACT,
        PH_TIE
    } t_phase;

    typedef enum logic [1:0] {
        CLS_EXACT,
        CLS_BELOW,
        CLS_TIE,
        CLS_ABOVE
    } t_cls;

    localparam logic signed [11:0] RES_HI = 12'(RES_MAX);
    localparam logic signed [11:0] RES_LO = 12'(RES_MIN);

    t_state         r_state;
    t_phase         r_phase;
    t_cls           r_cls;
    logic           r_out_valid;
    t_result        r_out;
    logic [7:0]     r_x;
    logic           r_last;
    logic signed [16:0] r_p;
    logic [7:0]     r_beta;
    logic [30:0]    r_d;
    logic           r_inval;
    logic           r_neg;
    logic [29:0]    r_a2;
    logic [8:0]     r_n;
    logic [3:0]     r_bit;
    logic           r_exact;
    logic [19:0]    r_sq;
    logic [50:0]    r_prod;

    logic signed [8:0]  diff;
    logic signed [16:0] p_full;
    logic signed [16:0] neg_p;
    logic [15:0]        ap;
    logic [31:0]        a2_full;
    logic               d_bad;
    logic [9:0]         v;
    logic [19:0]        sq_full;
    logic [50:0]        prod_full;
    logic [55:0]        a_cmp;
    logic [55:0]        a4_cmp;
    logic [55:0]        prod56;
    logic signed [10:0] n11;
    logic signed [10:0] fl;
    t_cls               cls_adj;
    logic signed [11:0] sum12;
    logic signed [11:0] rnd;
    logic               up;
    t_result            res_next;

    always_comb begin
        diff   = $signed({r_x[7], r_x}) - $signed({i_entry.mean[7], i_entry.mean});
        p_full = $signed({{9{i_entry.gamma[7]}}, i_entry.gamma}) *
                 $signed({{8{diff[8]}}, diff});
        d_bad  = i_entry.p_var[7] || ((i_entry.p_var == '0) && (i_eps == '0));

        neg_p   = -r_p;
        ap      = r_p[16] ? neg_p[15:0] : r_p[15:0];
        a2_full = {16'b0, ap} * {16'b0, ap};

        case (r_phase)
            PH_SEARCH: v = {1'b0, r_n | (9'd1 << r_bit)};
            PH_EXACT:  v = {1'b0, r_n};
            PH_TIE:    v = {r_n, 1'b1};
            default:   v = {1'b0, r_n};
        endcase
        sq_full   = {10'b0, v} * {10'b0, v};
        prod_full = {31'b0, r_sq} * {20'b0, r_d};

        a_cmp  = {2'b0, r_a2, 24'b0};
        a4_cmp = {r_a2, 26'b0};
        prod56 = {5'b0, r_prod};

        n11 = $signed({2'b0, r_n});
        if (!r_neg) begin
            fl      = n11;
            cls_adj = r_cls;
        end else if (r_cls == CLS_EXACT) begin
            fl      = -n11;
            cls_adj = r_cls;
        end else begin
            fl = -n11 - 11'sd1;
            case (r_cls)
                CLS_BELOW: cls_adj = CLS_ABOVE;
                CLS_ABOVE: cls_adj = CLS_BELOW;
                default:   cls_adj = r_cls;
            endcase
        end
        sum12 = $signed({{4{r_beta[7]}}, r_beta}) + $signed({fl[10], fl});
        up    = (cls_adj == CLS_ABOVE) || ((cls_adj == CLS_TIE) && sum12[0]);
        rnd   = sum12 + $signed({11'b0, up});

        res_next.last    = r_last;
        res_next.invalid = r_inval;
        if (r_inval) begin
            res_next.result  = '0;
            res_next.clipped = 1'b0;
        end else if (rnd > RES_HI) begin
            res_next.result  = RES_HI[7:0];
            res_next.clipped = 1'b1;
        end else if (rnd < RES_LO) begin
            res_next.result  = RES_LO[7:0];
            res_next.clipped = 1'b1;
        end else begin
            res_next.result  = rnd[7:0];
            res_next.clipped = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_ready && (r_state != S_RND)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_x     <= i_sample;
                        r_last  <= i_last;
                        r_state <= S_FETCH;
                    end
                end
                S_FETCH: begin
                    r_p     <= p_full;
                    r_beta  <= i_entry.beta;
                    r_d     <= {i_entry.p_var[6:0], i_eps};
                    r_inval <= d_bad;
                    r_state <= d_bad ? S_RND : S_ABS;
                end
                S_ABS: begin
                    r_a2    <= a2_full[29:0];
                    r_neg   <= r_p[16];
                    r_n     <= '0;
                    r_bit   <= 4'd8;
                    r_phase <= PH_SEARCH;
                    r_state <= S_SQ;
                end
                S_SQ: begin
                    r_sq    <= sq_full;
                    r_state <= S_PD;
                end
                S_PD: begin
                    r_prod  <= prod_full;
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    case (r_phase)
                        PH_SEARCH: begin
                            if (prod56 <= a_cmp) begin
                                r_n <= v[8:0];
                            end
                            if (r_bit == '0) begin
                                r_phase <= PH_EXACT;
                            end else begin
                                r_bit <= r_bit - 4'd1;
                            end
                            r_state <= S_SQ;
                        end
                        PH_EXACT: begin
                            r_exact <= (prod56 == a_cmp);
                            r_phase <= PH_TIE;
                            r_state <= S_SQ;
                        end
                        default: begin
                            if (r_exact) begin
                                r_cls <= CLS_EXACT;
                            end else if (a4_cmp < prod56) begin
                                r_cls <= CLS_BELOW;
                            end else if (a4_cmp == prod56) begin
                                r_cls <= CLS_TIE;
                            end else begin
                                r_cls <= CLS_ABOVE;
                            end
                            r_state <= S_RND;
                        end
                    endcase
                end
                S_RND: begin
                    if (!r_out_valid || i_ready) begin
                        r_out       <= res_next;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_idle   = (r_state == S_IDLE);
    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule
